>>> hdl/sswm_pkg.sv
// Shared types and constants for the soft-wrap substring matcher.
// Used by sswm_cell and soft_wrap_substring_matcher; depends on nothing.
`default_nettype none

package sswm_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int ROW_WIDTH_DEF   = 79;
   localparam int ROWS_DEF        = 32;

   localparam int PATTERN_CHARS   = 16;
   localparam int CHAR_W          = 8;
   localparam int LEN_W           = 5;
   localparam int START_ROW_W     = 5;
   localparam int START_COL_W     = 7;
   localparam int COUNT_W         = 10;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              hard_break;
      logic              first;
   } req_type;

   typedef struct packed {
      logic [START_ROW_W-1:0] start_row;
      logic [START_COL_W-1:0] start_column;
      logic [COUNT_W-1:0]     match_number;
   } rsp_type;

   typedef struct packed {
      logic [CHAR_W-1:0]      ch;
      logic [START_ROW_W-1:0] row;
      logic [START_COL_W-1:0] column;
   } entry_type;

   typedef struct packed {
      logic             advance;
      logic             clear;
      logic [LEN_W-1:0] len;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> hdl/sswm_cell.sv
// One window cell: holds one text character and its position, shifts to its neighbor,
// and compares the incoming character with its pattern character. Uses sswm_pkg.
`default_nettype none

module sswm_cell #(
   parameter int INDEX = 0
) (
   input  wire                                              clock,
   input  sswm_pkg::cell_ctrl_type                          ctrl,
   input  wire [sswm_pkg::PATTERN_CHARS*sswm_pkg::CHAR_W-1:0] pattern,
   input  sswm_pkg::entry_type                              shift_in,
   output sswm_pkg::entry_type                              shift_out,
   output logic                                             agree,
   output sswm_pkg::entry_type                              tap
);

   sswm_pkg::entry_type          entry_ff;
   sswm_pkg::entry_type          entry_in;
   logic [sswm_pkg::LEN_W-1:0]   pat_idx;
   logic [sswm_pkg::CHAR_W-1:0]  pat_char;
   logic                         in_use;
   logic                         selected;

   always_comb begin
      if (ctrl.clear && (INDEX != 0)) begin
         entry_in = '0;
      end else begin
         entry_in = shift_in;
      end
   end

   assign in_use   = int'(ctrl.len) > INDEX;
   assign selected = int'(ctrl.len) == INDEX + 1;
   assign pat_idx  = ctrl.len - sswm_pkg::LEN_W'(INDEX + 1);
   assign pat_char = pattern[{pat_idx[3:0], 3'b000} +: sswm_pkg::CHAR_W];
   assign agree    = !in_use || (entry_in.ch == pat_char);
   assign tap      = selected ? entry_in : '0;

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         entry_ff <= entry_in;
      end
   end

   assign shift_out = entry_ff;

endmodule

`default_nettype wire

>>> hdl/soft_wrap_substring_matcher.sv
// Top level of the soft-wrap substring matcher: window cell chain, position counters,
// match counter and result register. Uses sswm_pkg and sswm_cell.
//
// The block takes one text item per clock while req_stall is low, and reports a match in
// the cycle after it takes the item that completes it. This is set by the chain of window
// cells: every cell compares its incoming character with its pattern character in the
// cycle the item is taken, and the agreement of all cells is registered into the result
// stage. The result register frees up in the same cycle its item is taken, so input is
// stalled only while a result waits on a stalled output.
`default_nettype none

module soft_wrap_substring_matcher #(
   parameter int MAX_PATTERN = sswm_pkg::MAX_PATTERN_DEF,
   parameter int ROW_WIDTH   = sswm_pkg::ROW_WIDTH_DEF,
   parameter int ROWS        = sswm_pkg::ROWS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  sswm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output sswm_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_write_enable,
   input  wire [sswm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [sswm_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int RUN_W   = $clog2(MAX_PATTERN + 1);
   localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W   = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
   localparam int LEN_CAP = (MAX_PATTERN < sswm_pkg::PATTERN_CHARS) ?
                            MAX_PATTERN : sswm_pkg::PATTERN_CHARS;

   logic [sswm_pkg::CSR_DATA_W-1:0] pat_low_ff;
   logic [sswm_pkg::CSR_DATA_W-1:0] pat_high_ff;
   logic [sswm_pkg::LEN_W-1:0]      pat_len_ff;
   logic [sswm_pkg::LEN_W-1:0]      eff_len;

   logic [RUN_W-1:0]               run_ff;
   logic [RUN_W-1:0]               run_in;
   logic [RUN_W-1:0]               run_cur;
   logic [ROW_W-1:0]               row_ff;
   logic [ROW_W-1:0]               row_in;
   logic [ROW_W-1:0]               row_cur;
   logic [COL_W-1:0]               col_ff;
   logic [COL_W-1:0]               col_in;
   logic [COL_W-1:0]               col_cur;
   logic [sswm_pkg::COUNT_W-1:0]   cnt_ff;
   logic [sswm_pkg::COUNT_W-1:0]   cnt_in;
   logic [sswm_pkg::COUNT_W-1:0]   cnt_cur;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   sswm_pkg::rsp_type              rsp_ff;
   sswm_pkg::rsp_type              rsp_in;

   logic                           req_fire;
   logic                           hit;
   sswm_pkg::cell_ctrl_type        ctrl;
   sswm_pkg::entry_type            head;
   sswm_pkg::entry_type            chain [MAX_PATTERN];
   sswm_pkg::entry_type            taps  [MAX_PATTERN];
   sswm_pkg::entry_type            start_entry;
   logic [MAX_PATTERN-1:0]         agree;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= sswm_pkg::LEN_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sswm_pkg::REG_PATTERN_LOW:  pat_low_ff  <= csr_write_data;
            sswm_pkg::REG_PATTERN_HIGH: pat_high_ff <= csr_write_data;
            sswm_pkg::REG_PATTERN_LEN:  pat_len_ff  <= csr_write_data[sswm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (pat_len_ff == '0) begin
         eff_len = sswm_pkg::LEN_W'(1);
      end else if (int'(pat_len_ff) > LEN_CAP) begin
         eff_len = sswm_pkg::LEN_W'(LEN_CAP);
      end else begin
         eff_len = pat_len_ff;
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign run_cur = req_data.first ? '0 : run_ff;
   assign row_cur = req_data.first ? '0 : row_ff;
   assign col_cur = req_data.first ? '0 : col_ff;
   assign cnt_cur = req_data.first ? '0 : cnt_ff;

   assign ctrl.advance = req_fire;
   assign ctrl.clear   = req_data.first;
   assign ctrl.len     = eff_len;

   assign head.ch     = req_data.ch;
   assign head.row    = sswm_pkg::START_ROW_W'(row_cur);
   assign head.column = sswm_pkg::START_COL_W'(col_cur);

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      sswm_cell #(
         .INDEX (j)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pattern   ({pat_high_ff, pat_low_ff}),
         .shift_in  ((j == 0) ? head : chain[(j == 0) ? 0 : j - 1]),
         .shift_out (chain[j]),
         .agree     (agree[j]),
         .tap       (taps[j])
      );
   end

   always_comb begin
      start_entry = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         start_entry = start_entry | taps[j];
      end
   end

   always_comb begin
      logic [RUN_W-1:0] run_new;
      run_new = (int'(run_cur) < MAX_PATTERN) ? run_cur + RUN_W'(1) : run_cur;
      hit     = (int'(run_new) >= int'(eff_len)) && (&agree);
      run_in  = req_data.hard_break ? '0 : run_new;

      if (hit && (cnt_cur != sswm_pkg::COUNT_MAX)) begin
         cnt_in = cnt_cur + sswm_pkg::COUNT_W'(1);
      end else begin
         cnt_in = cnt_cur;
      end

      if (req_data.hard_break || (int'(col_cur) + 1 >= ROW_WIDTH)) begin
         col_in = '0;
         row_in = (int'(row_cur) + 1 >= ROWS) ? '0 : row_cur + ROW_W'(1);
      end else begin
         col_in = col_cur + COL_W'(1);
         row_in = row_cur;
      end

      rsp_in.start_row    = start_entry.row;
      rsp_in.start_column = start_entry.column;
      rsp_in.match_number = cnt_in;
   end

   always_comb begin
      priority if (req_fire) begin
         rsp_valid_in = hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            run_ff <= run_in;
            row_ff <= row_in;
            col_ff <= col_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(req_fire))
      else $error("result appeared without an accepted item");

   a_break_resets_column: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.hard_break |=> col_ff == '0)
      else $error("column not cleared after a hard break");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.first |=> cnt_ff >= $past(cnt_ff))
      else $error("match count went down without a new search");
`endif

endmodule

`default_nettype wire

>>> tb/soft_wrap_substring_matcher_tb.sv
// Self-checking testbench for soft_wrap_substring_matcher: a table of directed items,
// then random text with embedded patterns, checked against a match predictor.
// Depends on sswm_pkg and the matcher RTL only.

module soft_wrap_substring_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES     = 9;
   localparam int SETTLE_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int RANDOM_ITEMS     = 560;

   localparam logic [sswm_pkg::CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic [1:0] {ROW_CSR, ROW_HIT, ROW_MISS, ROW_PREDICT} row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [sswm_pkg::CSR_INDEX_W-1:0] csr_index;
      logic [sswm_pkg::CSR_DATA_W-1:0]  csr_value;
      sswm_pkg::req_type                item;
      sswm_pkg::rsp_type                result;
   } plan_row_type;

   typedef struct packed {
      row_kind_type      kind;
      sswm_pkg::rsp_type result;
   } verdict_type;

   localparam int PLAN_ROWS = 31;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'h00, 1'b0, 1'b1}, '{5'd0, 7'd0, 10'd1}},
      '{ROW_MISS,    REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'h00, 1'b1, 1'b0}, '{5'd0, 7'd2, 10'd2}},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'h00, 1'b0, 1'b0}, '{5'd1, 7'd0, 10'd3}},
      '{ROW_CSR,     sswm_pkg::REG_PATTERN_LOW, 64'hFF, '0, '0},
      '{ROW_CSR,     sswm_pkg::REG_PATTERN_LEN, 64'h0, '0, '0},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b1}, '{5'd0, 7'd0, 10'd1}},
      '{ROW_MISS,    REG_SPARE, 64'h0, '{8'h7F, 1'b0, 1'b0}, '0},
      '{ROW_CSR,     sswm_pkg::REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
      '{ROW_CSR,     sswm_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
      '{ROW_CSR,     sswm_pkg::REG_PATTERN_LEN, 64'd31, '0, '0},
      '{ROW_CSR,     REG_SPARE, 64'hDEAD_BEEF_0123_4567, '0, '0},
      '{ROW_MISS,    REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b1}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_PREDICT, REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '{5'd0, 7'd0, 10'd1}},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '{5'd0, 7'd1, 10'd2}},
      '{ROW_HIT,     REG_SPARE, 64'h0, '{8'hFF, 1'b1, 1'b0}, '{5'd0, 7'd2, 10'd3}},
      '{ROW_MISS,    REG_SPARE, 64'h0, '{8'hFF, 1'b0, 1'b0}, '0}
   };

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   sswm_pkg::req_type                req_data         = '0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   sswm_pkg::rsp_type                rsp_data;
   logic                             csr_write_enable = 1'b0;
   logic [sswm_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [sswm_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   logic [sswm_pkg::CSR_DATA_W-1:0] pat_low     = '0;
   logic [sswm_pkg::CSR_DATA_W-1:0] pat_high    = '0;
   logic [sswm_pkg::LEN_W-1:0]      pat_len_reg = sswm_pkg::LEN_W'(1);

   logic [sswm_pkg::CHAR_W-1:0]  recent_chars  [sswm_pkg::MAX_PATTERN_DEF];
   logic [11:0]                  recent_places [sswm_pkg::MAX_PATTERN_DEF];
   int                           chain_len   = 0;
   int                           row_pos     = 0;
   int                           col_pos     = 0;
   logic [sswm_pkg::COUNT_W-1:0] found_count = '0;

   sswm_pkg::rsp_type expected_matches [$];
   verdict_type       row_verdicts [$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   int items_sent    = 0;
   int text_column   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   soft_wrap_substring_matcher DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      foreach (recent_chars[i]) begin
         recent_chars[i]  = '0;
         recent_places[i] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic logic [sswm_pkg::CHAR_W-1:0] pattern_char(input int k);
      return (k < 8) ? pat_low[k*8 +: 8] : pat_high[(k-8)*8 +: 8];
   endfunction

   function automatic int active_length();
      int n;
      n = pat_len_reg;
      if (n == 0) n = 1;
      if (n > sswm_pkg::PATTERN_CHARS) n = sswm_pkg::PATTERN_CHARS;
      if (n > sswm_pkg::MAX_PATTERN_DEF) n = sswm_pkg::MAX_PATTERN_DEF;
      return n;
   endfunction

   function automatic bit predict_match(input sswm_pkg::req_type item,
                                        output sswm_pkg::rsp_type found);
      int  i;
      int  k;
      int  n;
      bit  hit;
      if (item.first) begin
         foreach (recent_chars[j]) begin
            recent_chars[j]  = '0;
            recent_places[j] = '0;
         end
         chain_len   = 0;
         row_pos     = 0;
         col_pos     = 0;
         found_count = '0;
      end
      for (i = sswm_pkg::MAX_PATTERN_DEF - 1; i > 0; i--) begin
         recent_chars[i]  = recent_chars[i-1];
         recent_places[i] = recent_places[i-1];
      end
      recent_chars[0]  = item.ch;
      recent_places[0] = {row_pos[4:0], col_pos[6:0]};
      if (chain_len < sswm_pkg::MAX_PATTERN_DEF) chain_len++;

      n   = active_length();
      hit = (chain_len >= n);
      for (k = 0; k < n; k++) begin
         if (recent_chars[n-1-k] != pattern_char(k)) hit = 1'b0;
      end

      found = '0;
      if (hit) begin
         if (found_count != sswm_pkg::COUNT_MAX) found_count++;
         found.start_row    = recent_places[n-1][11:7];
         found.start_column = recent_places[n-1][6:0];
         found.match_number = found_count;
      end

      if (item.hard_break) chain_len = 0;
      if (item.hard_break || col_pos + 1 >= sswm_pkg::ROW_WIDTH_DEF) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= sswm_pkg::ROWS_DEF) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
      return hit;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      sswm_pkg::rsp_type want;
      sswm_pkg::rsp_type predicted;
      verdict_type       verdict;
      bit                hit;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $error("unexpected match: row %0d, column %0d, number %0d",
                      rsp_data.start_row, rsp_data.start_column, rsp_data.match_number);
               error_count++;
            end else begin
               want = expected_matches.pop_front();
               check_field("start_row", want.start_row, rsp_data.start_row);
               check_field("start_column", want.start_column, rsp_data.start_column);
               check_field("match_number", want.match_number, rsp_data.match_number);
            end
         end
         if (req_valid && !req_stall) begin
            verdict = row_verdicts.pop_front();
            hit     = predict_match(req_data, predicted);
            if (verdict.kind == ROW_HIT) begin
               expected_matches.push_back(verdict.result);
            end else if (verdict.kind == ROW_PREDICT && hit) begin
               expected_matches.push_back(predicted);
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[soft_wrap_substring_matcher] ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input sswm_pkg::req_type item, input row_kind_type kind,
                            input sswm_pkg::rsp_type typed);
      int col;
      row_verdicts.push_back('{kind, typed});
      col         = item.first ? 0 : text_column;
      text_column = (item.hard_break || col == sswm_pkg::ROW_WIDTH_DEF - 1) ? 0 : col + 1;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text_char(input logic [sswm_pkg::CHAR_W-1:0] ch, input int break_pct,
                                 input int first_permille);
      sswm_pkg::req_type item;
      int                col;
      item.ch         = ch;
      item.first      = ($urandom_range(999) < first_permille);
      col             = item.first ? 0 : text_column;
      item.hard_break = ($urandom_range(99) < break_pct) ||
                        (col == sswm_pkg::ROW_WIDTH_DEF - 1 && $urandom_range(3) == 0);
      items_sent++;
      send_item(item, ROW_PREDICT, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [sswm_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [sswm_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         sswm_pkg::REG_PATTERN_LOW:  pat_low     = value;
         sswm_pkg::REG_PATTERN_HIGH: pat_high    = value;
         sswm_pkg::REG_PATTERN_LEN:  pat_len_reg = value[sswm_pkg::LEN_W-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random_pattern();
      logic [sswm_pkg::CSR_DATA_W-1:0] low;
      logic [sswm_pkg::CSR_DATA_W-1:0] high;
      logic [sswm_pkg::CSR_DATA_W-1:0] len_word;
      logic [sswm_pkg::CHAR_W-1:0]     a;
      logic [sswm_pkg::CHAR_W-1:0]     b;
      int                              k;
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      case ($urandom_range(5))
         0: begin
            low  = {$urandom, $urandom};
            high = {$urandom, $urandom};
         end
         4: begin
            low  = '0;
            high = '0;
         end
         5: begin
            low  = '1;
            high = '1;
         end
         default: begin
            for (k = 0; k < 8; k++) begin
               low[k*8 +: 8]  = $urandom_range(1) ? a : b;
               high[k*8 +: 8] = $urandom_range(1) ? a : b;
            end
         end
      endcase
      case ($urandom_range(7))
         0: len_word = '0;
         1: len_word = 64'd1;
         2: len_word = 64'd16;
         3: len_word = 64'($urandom_range(31, 17));
         4: len_word = {$urandom, $urandom};
         default: len_word = 64'($urandom_range(8, 2));
      endcase
      drain();
      write_register(sswm_pkg::REG_PATTERN_LOW, low);
      write_register(sswm_pkg::REG_PATTERN_HIGH, high);
      write_register(sswm_pkg::REG_PATTERN_LEN, len_word);
      if ($urandom_range(3) == 0) write_register(REG_SPARE, {$urandom, $urandom});
   endtask

   task automatic run_phase(input int item_goal, input int break_pct);
      logic [sswm_pkg::CHAR_W-1:0] seg [$];
      int                          sent;
      int                          n;
      int                          k;
      int                          j;
      int                          span;
      sent = 0;
      while (sent < item_goal) begin
         seg.delete();
         n = active_length();
         case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
               for (k = 0; k < n; k++) seg.push_back(pattern_char(k));
            end
            5: begin
               span = (n > 1) ? $urandom_range(n - 1, 1) : 1;
               for (k = 0; k < span; k++) seg.push_back(pattern_char(k));
            end
            6: begin
               for (k = 0; k < n; k++) seg.push_back(pattern_char(k));
               j      = $urandom_range(n - 1);
               seg[j] = seg[j] ^ 8'($urandom_range(255, 1));
            end
            7, 8: begin
               repeat ($urandom_range(3, 1)) seg.push_back(pattern_char($urandom_range(n - 1)));
            end
            default: begin
               repeat ($urandom_range(3, 1)) seg.push_back(8'($urandom_range(255)));
            end
         endcase
         foreach (seg[i]) send_text_char(seg[i], break_pct, 5);
         sent += seg.size();
         if ($urandom_range(49) == 0) drain();
      end
   endtask

   initial begin : stimulus
      int i;
      int break_pct;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      rsp_stall_pct = 83;
      for (i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].kind == ROW_CSR) begin
            drain();
            write_register(PLAN[i].csr_index, PLAN[i].csr_value);
         end else begin
            send_item(PLAN[i].item, PLAN[i].kind, PLAN[i].result);
         end
      end

      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end else if (items_sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct = 83;
            rsp_stall_pct = 38;
         end
         load_random_pattern();
         case ($urandom_range(3))
            0: break_pct = 0;
            1: break_pct = 2;
            2: break_pct = 10;
            default: break_pct = 35;
         endcase
         run_phase($urandom_range(90, 40), break_pct);
      end
      drain();

      if (error_count == 0) begin
         $display("[soft_wrap_substring_matcher] OK");
      end else begin
         $display("[soft_wrap_substring_matcher] ERROR");
      end
      $finish;
   end

endmodule
